@@ hdl/rsrct_pkg.sv @@
// Shared constants, types and helpers for the range set / range count tree.
`timescale 1ns / 1ps

package rsrct_pkg;

  // Domain and field geometry
  localparam int DOMAIN_BITS = 16;
  localparam int POS_W       = 16;
  localparam int SET_COUNT_W = 17;
  localparam int NODE_AW     = DOMAIN_BITS + 1;
  localparam int NODES       = 1 << NODE_AW;
  localparam int COUNT_W     = DOMAIN_BITS + 1;
  localparam int NODE_W      = COUNT_W + 1;
  localparam int LVL_W       = $clog2(DOMAIN_BITS + 1);
  localparam int SP_W        = $clog2(DOMAIN_BITS + 1);
  localparam int STK_IW      = $clog2(DOMAIN_BITS);
  localparam int CMP_W       = (DOMAIN_BITS > POS_W) ? DOMAIN_BITS : POS_W;

  localparam logic [CMP_W-1:0]       LAST_POS = CMP_W'((64'd1 << DOMAIN_BITS) - 64'd1);
  localparam logic [DOMAIN_BITS-1:0] ALL_ONES = '1;

  // Request modes
  localparam logic MODE_SET   = 1'b0;
  localparam logic MODE_COUNT = 1'b1;

  // Walk phase of a tree frame
  localparam logic [1:0] PH_NEW   = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_POST  = 2'd2;

  // Node store address select
  localparam logic [1:0] AS_NODE  = 2'd0;
  localparam logic [1:0] AS_LEFT  = 2'd1;
  localparam logic [1:0] AS_RIGHT = 2'd2;
  localparam logic [1:0] AS_CLEAR = 2'd3;

  // Node store write data select
  localparam logic [1:0] DS_FULL = 2'd0;
  localparam logic [1:0] DS_SPAN = 2'd1;
  localparam logic [1:0] DS_SUM  = 2'd2;
  localparam logic [1:0] DS_ZERO = 2'd3;

  typedef struct packed {
    logic               full;
    logic [COUNT_W-1:0] cnt;
  } node_t;

  typedef struct packed {
    logic [NODE_AW-1:0]     node;
    logic [DOMAIN_BITS-1:0] lo;
    logic [LVL_W-1:0]       lvl;
    logic [1:0]             ph;
  } frame_t;

  typedef struct packed {
    logic       load;
    logic       clr_step;
    logic       ram_en;
    logic       ram_we;
    logic [1:0] addr_sel;
    logic [1:0] data_sel;
    logic       push_left;
    logic       push_right;
    logic       pop;
    logic       acc_add;
    logic       latch_left;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       mode;
    logic       empty;
    logic       disjoint;
    logic       covered;
    logic       full;
    logic [1:0] ph;
    logic       stk_empty;
    logic       clr_last;
    logic       out_free;
  } sts_t;

  // Count seen through a full mark
  function automatic logic [COUNT_W-1:0] eff(input node_t n, input logic [COUNT_W-1:0] span);
    eff = n.full ? span : n.cnt;
  endfunction

endpackage

@@ hdl/rsrct_if.sv @@
// Request and result channel interfaces.
`timescale 1ns / 1ps

interface rsrct_req_if;
  import rsrct_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [POS_W-1:0] range_low;
  logic [POS_W-1:0] range_high;
  modport source (output valid, mode, range_low, range_high, input ready);
  modport sink   (input valid, mode, range_low, range_high, output ready);
endinterface

interface rsrct_res_if;
  import rsrct_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SET_COUNT_W-1:0] set_count;
  modport source (output valid, set_count, input ready);
  modport sink   (input valid, set_count, output ready);
endinterface

@@ hdl/range_set_range_count_tree.sv @@
// Top level: range set / range count segment tree over 2^DOMAIN_BITS positions.
// Walk: an item walks the tree over one single-port node store; a count item ends with a
//   result load, which waits while the last result is held.
// Throughput: one item at a time; the next item is taken once the walk and any result load have ended.
// Reset: synchronous, active low; a sweep then zeroes all 2^(DOMAIN_BITS+1) node words,
//   during which no item is accepted.
`timescale 1ns / 1ps

module range_set_range_count_tree (
  input logic         clk,
  input logic         rst_n,
  rsrct_req_if.sink   in_ch,
  rsrct_res_if.source out_ch
);
  import rsrct_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  rsrct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsrct_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_mode       (in_ch.mode),
    .in_range_low  (in_ch.range_low),
    .in_range_high (in_ch.range_high),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_set_count (out_ch.set_count),
    .sts           (sts)
  );

endmodule

@@ hdl/rsrct_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module rsrct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read one word
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/rsrct_dp.sv @@
// Datapath: node store, walk stack, range compare, count accumulator, result register.
`timescale 1ns / 1ps

module rsrct_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rsrct_pkg::cmd_t                  cmd,
  input  logic                             in_mode,
  input  logic [rsrct_pkg::POS_W-1:0]      in_range_low,
  input  logic [rsrct_pkg::POS_W-1:0]      in_range_high,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [rsrct_pkg::SET_COUNT_W-1:0] out_set_count,
  output rsrct_pkg::sts_t                  sts
);
  import rsrct_pkg::*;

  logic                   mode_r;
  logic [CMP_W-1:0]       a_r;
  logic [CMP_W-1:0]       b_r;
  frame_t                 cur_r;
  frame_t                 stk_r [DOMAIN_BITS];
  logic [SP_W-1:0]        sp_r;
  logic [COUNT_W-1:0]     acc_r;
  logic [COUNT_W-1:0]     effl_r;
  logic [NODE_AW-1:0]     clr_r;
  logic                   out_valid_r;
  logic [SET_COUNT_W-1:0] out_cnt_r;

  logic [DOMAIN_BITS-1:0] mask;
  logic [DOMAIN_BITS-1:0] hi;
  logic [DOMAIN_BITS-1:0] rlo;
  logic [CMP_W-1:0]       lo_c;
  logic [CMP_W-1:0]       hi_c;
  logic [CMP_W-1:0]       b_in;
  logic [COUNT_W-1:0]     span;
  logic [COUNT_W-1:0]     cspan;
  logic [NODE_AW-1:0]     lnode;
  logic [NODE_AW-1:0]     rnode;
  logic [NODE_AW-1:0]     addr;
  logic [NODE_W-1:0]      rdata;
  node_t                  rd;
  node_t                  wd;
  frame_t                 push_frame;
  logic [STK_IW-1:0]      wi;
  logic [STK_IW-1:0]      ri;

  // Span and children of the current node
  always_comb begin
    mask  = ALL_ONES >> cur_r.lvl;
    hi    = cur_r.lo | mask;
    rlo   = cur_r.lo | (mask & ~(mask >> 1));
    lo_c  = CMP_W'(cur_r.lo);
    hi_c  = CMP_W'(hi);
    span  = COUNT_W'(mask) + COUNT_W'(1);
    cspan = COUNT_W'(mask >> 1) + COUNT_W'(1);
    lnode = {cur_r.node[NODE_AW-2:0], 1'b0};
    rnode = {cur_r.node[NODE_AW-2:0], 1'b1};
    b_in  = (CMP_W'(in_range_high) > LAST_POS) ? LAST_POS : CMP_W'(in_range_high);
    rd    = node_t'(rdata);
    wi    = sp_r[STK_IW-1:0];
    ri    = STK_IW'(sp_r - SP_W'(1));
    push_frame    = cur_r;
    push_frame.ph = cmd.push_left ? PH_RIGHT : PH_POST;
  end

  // Select store address
  always_comb begin
    case (cmd.addr_sel)
      AS_NODE:  addr = cur_r.node;
      AS_LEFT:  addr = lnode;
      AS_RIGHT: addr = rnode;
      default:  addr = clr_r;
    endcase
  end

  // Select store write word
  always_comb begin
    case (cmd.data_sel)
      DS_FULL: wd = '{full: 1'b1, cnt: '0};
      DS_SPAN: wd = '{full: 1'b0, cnt: span};
      DS_SUM:  wd = '{full: 1'b0, cnt: effl_r + eff(rd, cspan)};
      default: wd = '{full: 1'b0, cnt: '0};
    endcase
  end

  rsrct_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES)
  ) u_store (
    .clk   (clk),
    .en    (cmd.ram_en),
    .we    (cmd.ram_we),
    .addr  (addr),
    .wdata (wd),
    .rdata (rdata)
  );

  // Latch request, walk the tree, accumulate
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      a_r    <= CMP_W'(in_range_low);
      b_r    <= b_in;
      cur_r  <= '{node: NODE_AW'(1), lo: '0, lvl: '0, ph: PH_NEW};
      acc_r  <= '0;
    end else begin
      if (cmd.push_left) begin
        stk_r[wi] <= push_frame;
        cur_r     <= '{node: lnode, lo: cur_r.lo, lvl: cur_r.lvl + LVL_W'(1), ph: PH_NEW};
      end else if (cmd.push_right) begin
        stk_r[wi] <= push_frame;
        cur_r     <= '{node: rnode, lo: rlo, lvl: cur_r.lvl + LVL_W'(1), ph: PH_NEW};
      end else if (cmd.pop) begin
        cur_r <= stk_r[ri];
      end
      if (cmd.acc_add) begin
        acc_r <= acc_r + eff(rd, span);
      end
    end
    if (cmd.latch_left) begin
      effl_r <= eff(rd, cspan);
    end
    if (cmd.out_load) begin
      out_cnt_r <= SET_COUNT_W'(acc_r);
    end
  end

  // Control registers: stack pointer, clear sweep, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        sp_r <= '0;
      end else if (cmd.push_left || cmd.push_right) begin
        sp_r <= sp_r + SP_W'(1);
      end else if (cmd.pop) begin
        sp_r <= sp_r - SP_W'(1);
      end
      if (cmd.clr_step) begin
        clr_r <= clr_r + NODE_AW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Report status
  always_comb begin
    sts.mode      = mode_r;
    sts.empty     = a_r > b_r;
    sts.disjoint  = (b_r < lo_c) || (hi_c < a_r);
    sts.covered   = (a_r <= lo_c) && (hi_c <= b_r);
    sts.full      = rd.full;
    sts.ph        = cur_r.ph;
    sts.stk_empty = sp_r == '0;
    sts.clr_last  = clr_r == '1;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_set_count = out_cnt_r;

endmodule

@@ hdl/rsrct_ctrl.sv @@
// Controller: sequences the clear sweep and the tree walk of each item.
`timescale 1ns / 1ps

module rsrct_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rsrct_pkg::sts_t sts,
  output rsrct_pkg::cmd_t cmd
);
  import rsrct_pkg::*;

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_VISIT  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_WFL    = 4'd5;
  localparam logic [3:0] S_WFR    = 4'd6;
  localparam logic [3:0] S_RDR    = 4'd7;
  localparam logic [3:0] S_SUM    = 4'd8;
  localparam logic [3:0] S_POP    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode state into datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.ram_en   = 1'b1;
        cmd.ram_we   = 1'b1;
        cmd.addr_sel = AS_CLEAR;
        cmd.data_sel = DS_ZERO;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.empty) begin
          state_nxt = (sts.mode == MODE_COUNT) ? S_FIN : S_IDLE;
        end else begin
          state_nxt = S_VISIT;
        end
      end
      S_VISIT: begin
        case (sts.ph)
          PH_NEW: begin
            if (sts.disjoint) begin
              state_nxt = S_POP;
            end else begin
              cmd.ram_en   = 1'b1;
              cmd.addr_sel = AS_NODE;
              state_nxt    = S_DECIDE;
            end
          end
          PH_RIGHT: begin
            cmd.push_right = 1'b1;
          end
          default: begin
            if (sts.mode == MODE_SET) begin
              cmd.ram_en   = 1'b1;
              cmd.addr_sel = AS_LEFT;
              state_nxt    = S_RDR;
            end else begin
              state_nxt = S_POP;
            end
          end
        endcase
      end
      S_DECIDE: begin
        if (sts.mode == MODE_SET) begin
          if (sts.covered || sts.full) begin
            cmd.ram_en   = 1'b1;
            cmd.ram_we   = 1'b1;
            cmd.addr_sel = AS_NODE;
            cmd.data_sel = DS_FULL;
            state_nxt    = S_POP;
          end else begin
            cmd.push_left = 1'b1;
            state_nxt     = S_VISIT;
          end
        end else if (sts.covered) begin
          cmd.acc_add = 1'b1;
          state_nxt   = S_POP;
        end else if (sts.full) begin
          // push the full mark down to both children
          cmd.ram_en   = 1'b1;
          cmd.ram_we   = 1'b1;
          cmd.addr_sel = AS_NODE;
          cmd.data_sel = DS_SPAN;
          state_nxt    = S_WFL;
        end else begin
          cmd.push_left = 1'b1;
          state_nxt     = S_VISIT;
        end
      end
      S_WFL: begin
        cmd.ram_en   = 1'b1;
        cmd.ram_we   = 1'b1;
        cmd.addr_sel = AS_LEFT;
        cmd.data_sel = DS_FULL;
        state_nxt    = S_WFR;
      end
      S_WFR: begin
        cmd.ram_en    = 1'b1;
        cmd.ram_we    = 1'b1;
        cmd.addr_sel  = AS_RIGHT;
        cmd.data_sel  = DS_FULL;
        cmd.push_left = 1'b1;
        state_nxt     = S_VISIT;
      end
      S_RDR: begin
        cmd.latch_left = 1'b1;
        cmd.ram_en     = 1'b1;
        cmd.addr_sel   = AS_RIGHT;
        state_nxt      = S_SUM;
      end
      S_SUM: begin
        cmd.ram_en   = 1'b1;
        cmd.ram_we   = 1'b1;
        cmd.addr_sel = AS_NODE;
        cmd.data_sel = DS_SUM;
        state_nxt    = S_POP;
      end
      S_POP: begin
        if (sts.stk_empty) begin
          state_nxt = (sts.mode == MODE_COUNT) ? S_FIN : S_IDLE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_VISIT;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ verif/rsrct_checker.sv @@
// Checker for the range set / range count tree: watches both channels, predicts, compares.
`timescale 1ns / 1ps

module rsrct_checker (
  input  logic        clk,
  input  logic        rst_n,
  rsrct_req_if        req,
  rsrct_res_if        res,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import rsrct_pkg::*;

  localparam int ROW_W = 256;
  localparam int ROWS  = (1 << DOMAIN_BITS) / ROW_W;

  // Bitmap of set positions, kept as rows of 256 positions
  logic [ROW_W-1:0]       occupied [ROWS];
  logic [SET_COUNT_W-1:0] count_queue [$];

  // Mask of bits lo..hi within one row
  function automatic logic [ROW_W-1:0] row_mask(input int lo, input int hi);
    logic [ROW_W-1:0] ones;
    ones = '1;
    return (ones << lo) & (ones >> (ROW_W - 1 - hi));
  endfunction

  // Mark an inclusive range of positions as set
  task automatic mark_range(input int first, input int last);
    int lo, hi;
    if (first > last) return;
    for (int w = first / ROW_W; w <= last / ROW_W; w++) begin
      lo = (w == first / ROW_W) ? first % ROW_W : 0;
      hi = (w == last / ROW_W) ? last % ROW_W : ROW_W - 1;
      occupied[w] |= row_mask(lo, hi);
    end
  endtask

  // Number of set positions within an inclusive range
  function automatic logic [SET_COUNT_W-1:0] range_population(input int first, input int last);
    int lo, hi, total;
    total = 0;
    if (first > last) return '0;
    for (int w = first / ROW_W; w <= last / ROW_W; w++) begin
      lo = (w == first / ROW_W) ? first % ROW_W : 0;
      hi = (w == last / ROW_W) ? last % ROW_W : ROW_W - 1;
      total += $countones(occupied[w] & row_mask(lo, hi));
    end
    return SET_COUNT_W'(total);
  endfunction

  always @(posedge clk) begin
    int first, last;
    logic [SET_COUNT_W-1:0] want;
    if (!rst_n) begin
      for (int w = 0; w < ROWS; w++) occupied[w] = '0;
      count_queue.delete();
      fail_count    <= 0;
      result_count  <= 0;
    end else begin
      // Predict on each accepted request item
      if (req.valid && req.ready) begin
        first = int'(req.range_low);
        last  = int'(req.range_high);
        if (last > int'(LAST_POS)) last = int'(LAST_POS);
        if (req.mode == MODE_SET) mark_range(first, last);
        else count_queue.push_back(range_population(first, last));
      end
      // Compare each accepted result item with the oldest expectation
      if (res.valid && res.ready) begin
        result_count <= result_count + 1;
        if (count_queue.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result set_count=%0d", $realtime, res.set_count);
          fail_count <= fail_count + 1;
        end else begin
          want = count_queue.pop_front();
          if (res.set_count !== want) begin
            if (fail_count < 10)
              $display("%0t: set_count mismatch: expected %0d, got %0d",
                       $realtime, want, res.set_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= count_queue.size();
  end

endmodule

@@ verif/range_set_range_count_tree_tb.sv @@
// Testbench top: drives requests and result back-pressure, gives the verdict.
`timescale 1ns / 1ps

module range_set_range_count_tree_tb;
  import rsrct_pkg::*;

  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int     RANDOM_ITEMS = 1200;
  localparam int     LONG_HOLD    = 3000;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_request;
  int   hold_left;
  logic hold_done;
  int   fails, pending, results;
  int   set_items, count_items;
  longint cycles;

  rsrct_req_if req_ch ();
  rsrct_res_if res_ch ();

  range_set_range_count_tree uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (res_ch.source)
  );

  rsrct_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req_ch),
    .res           (res_ch),
    .fail_count    (fails),
    .pending_count (pending),
    .result_count  (results)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort on a run that never finishes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_left    <= LONG_HOLD;
      hold_done    <= 1'b1;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one request item and hold it until accepted
  task automatic send_request(input logic mode, input int first, input int last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= mode;
    req_ch.range_low  <= POS_W'(first);
    req_ch.range_high <= POS_W'(last);
    do @(posedge clk); while (!req_ch.ready);
    if (mode == MODE_SET) set_items++;
    else count_items++;
  endtask

  // Random request: mostly narrow ranges so the bitmap stays sparse for a while
  task automatic send_random_request();
    logic mode;
    int   first, last, pick;
    mode = $urandom_range(1) ? MODE_COUNT : MODE_SET;
    pick = $urandom_range(99);
    first = $urandom_range(65535);
    if (pick < 60) begin
      last = first + $urandom_range(64);
    end else if (pick < 80) begin
      last = first + $urandom_range(4096);
    end else if (pick < 90) begin
      if (mode == MODE_SET) last = first + $urandom_range(255);
      else last = $urandom_range(65535);
    end else if (pick < 95) begin
      last = first - 1 - $urandom_range(300);
      if (first == 0) last = 65535 - $urandom_range(1000);
    end else begin
      if (mode == MODE_COUNT) begin
        first = 0;
        last  = 65535;
      end else begin
        last = $urandom_range(65535);
        first = $urandom_range(65535);
      end
    end
    if (last > 65535) last = 65535;
    if (last < 0) last = 0;
    send_request(mode, first, last);
  endtask

  initial begin
    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= MODE_SET;
    req_ch.range_low  <= '0;
    req_ch.range_high <= '0;
    hold_request      = 1'b0;
    send_idle_pct     = 38;
    recv_idle_pct     = 65;
    cycles            = 0;
    set_items         = 0;
    count_items       = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty tree, edges, empty ranges, overlaps, full domain
    send_request(MODE_COUNT, 0, 65535);
    send_request(MODE_COUNT, 65535, 0);
    send_request(MODE_SET, 65535, 0);
    send_request(MODE_SET, 0, 0);
    send_request(MODE_SET, 65535, 65535);
    send_request(MODE_COUNT, 0, 65535);
    send_request(MODE_COUNT, 0, 0);
    send_request(MODE_COUNT, 65535, 65535);
    send_request(MODE_SET, 100, 200);
    send_request(MODE_SET, 150, 300);
    send_request(MODE_COUNT, 120, 180);
    send_request(MODE_COUNT, 0, 400);
    send_request(MODE_SET, 32767, 32768);
    send_request(MODE_COUNT, 32767, 32767);
    send_request(MODE_COUNT, 32768, 65535);
    send_request(MODE_COUNT, 1, 0);
    send_request(MODE_SET, 21845, 43690);
    send_request(MODE_COUNT, 21000, 44000);
    send_request(MODE_COUNT, 30000, 30001);
    send_request(MODE_COUNT, 43690, 43690);

    // Random in three idling phases; long receiver hold-off at the start of the last
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 65;
        recv_idle_pct = 38;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
      end
      if (n == RANDOM_ITEMS - 20) send_request(MODE_SET, 0, 65535);
      else send_random_request();
    end
    send_request(MODE_COUNT, 0, 65535);
    send_request(MODE_COUNT, 12345, 54321);
    req_ch.valid <= 1'b0;

    // Let the checker see the last item, drain, then let the last walk settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("Sent %0d set and %0d count items; %0d results checked.",
             set_items, count_items, results);
    $display("Covered empty and edge ranges, overlaps, full domain and a long output stall.");
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
